@@ hdl/safety_state_machine_link_watchdog_core_macros.svh @@
// Assertion helpers shared by the watchdog queue and back-end files.
`ifndef SAFETY_STATE_MACHINE_LINK_WATCHDOG_CORE_MACROS_SVH
`define SAFETY_STATE_MACHINE_LINK_WATCHDOG_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SSLW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define SSLW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/sslw_pkg.sv @@
`default_nettype none

package sslw_pkg;

  typedef enum logic [2:0] {
    MODE_INIT   = 3'd0,
    MODE_SAFE   = 3'd1,
    MODE_TEST   = 3'd2,
    MODE_UNSAFE = 3'd3,
    MODE_IGNITE = 3'd4,
    MODE_ABORT  = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    CFG_OWN_ID   = 3'd0,
    CFG_BCAST_ID = 3'd1,
    CFG_REQ_CODE = 3'd2,
    CFG_MIN_HDR  = 3'd3,
    CFG_TIMEOUT  = 3'd4
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [7:0]  OwnIdRst    = 8'd0;
  localparam logic [7:0]  BcastIdRst  = 8'd255;
  localparam logic [7:0]  ReqCodeRst  = 8'd0;
  localparam logic [7:0]  MinHdrRst   = 8'd16;
  localparam logic [15:0] TimeoutRst  = 16'd500;
  // byte holding the requested state code
  localparam logic [15:0] ReqByteOfs  = 16'd15;
  localparam logic [7:0]  MaxModeCode = 8'd5;

  typedef struct packed {
    logic        kind;
    logic [31:0] now_ms;
    logic [15:0] datagram_length;
    logic [7:0]  target_device;
    logic [7:0]  payload_kind;
    logic [7:0]  requested_state;
  } in_item_t;

  typedef struct packed {
    logic [2:0] machine_state;
    logic       request_taken;
    logic       timeout_abort;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  own_id;
    logic [7:0]  bcast_id;
    logic [7:0]  req_code;
    logic [7:0]  min_hdr;
    logic [15:0] timeout;
  } cfg_t;

  // classified item handed from front to back
  typedef struct packed {
    logic        is_tick;
    logic [31:0] now_ms;
    logic        hdr_ok;
    logic        req_ok;
    mode_e       req_state;
  } cls_item_t;

  function automatic logic move_ok(mode_e cur, mode_e req);
    logic ok;
    ok = 1'b0;
    unique case (cur)
      MODE_SAFE:   ok = (req == MODE_TEST) || (req == MODE_UNSAFE);
      MODE_TEST:   ok = (req == MODE_SAFE);
      MODE_UNSAFE: ok = (req == MODE_SAFE) || (req == MODE_IGNITE) || (req == MODE_ABORT);
      MODE_IGNITE: ok = (req == MODE_SAFE) || (req == MODE_ABORT);
      MODE_ABORT:  ok = (req == MODE_SAFE);
      default:     ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

`default_nettype wire

@@ hdl/sslw_front.sv @@
`default_nettype none

module sslw_front (
  input  wire                   in_valid_i,
  input  sslw_pkg::in_item_t    in_item_i,
  input  sslw_pkg::cfg_t        cfg_i,
  input  wire                   q_full_i,
  output logic                  in_stall_o,
  output logic                  push_o,
  output sslw_pkg::cls_item_t   cls_o
);

  logic addressed;

  assign addressed = (in_item_i.target_device == cfg_i.own_id)
                  || (in_item_i.target_device == cfg_i.bcast_id);

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    cls_o.is_tick   = !in_item_i.kind;
    cls_o.now_ms    = in_item_i.now_ms;
    cls_o.hdr_ok    = in_item_i.datagram_length >= {8'd0, cfg_i.min_hdr};
    // codes above abort are never a legal target
    cls_o.req_ok    = addressed
                   && (in_item_i.payload_kind == cfg_i.req_code)
                   && (in_item_i.datagram_length > sslw_pkg::ReqByteOfs)
                   && (in_item_i.requested_state <= sslw_pkg::MaxModeCode);
    cls_o.req_state = sslw_pkg::mode_e'(in_item_i.requested_state[2:0]);
  end

endmodule

`default_nettype wire

@@ hdl/sslw_queue.sv @@
`default_nettype none
`include "safety_state_machine_link_watchdog_core_macros.svh"

module sslw_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               push_i,
  input  wire [Width-1:0]   data_i,
  input  wire               pop_i,
  output logic              full_o,
  output logic              valid_o,
  output logic [Width-1:0]  data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             push, pop;

  assign push    = push_i && !full_o;
  assign pop     = pop_i && valid_o;
  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `SSLW_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CntW'(Depth), "queue count above depth")
  `SSLW_ASSERT_NEXT(a_cnt_inc, push && !pop, cnt_q == $past(cnt_q) + CntW'(1), "count did not grow")

endmodule

`default_nettype wire

@@ hdl/sslw_back.sv @@
`default_nettype none
`include "safety_state_machine_link_watchdog_core_macros.svh"

module sslw_back (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   q_valid_i,
  input  sslw_pkg::cls_item_t   cls_i,
  input  wire [15:0]            timeout_i,
  output logic                  pop_o,
  input  wire                   out_stall_i,
  output logic                  out_valid_o,
  output sslw_pkg::out_item_t   out_item_o
);

  sslw_pkg::mode_e     mode_q, mode_d;
  logic [31:0]         time_q, time_d;
  logic [31:0]         last_q, last_d;
  logic                out_valid_q, out_valid_d;
  sslw_pkg::out_item_t out_q, out_d;
  logic [31:0]         elapsed;
  logic                armed;
  logic                tmo;
  logic                taken;

  assign pop_o   = q_valid_i && (!out_valid_q || !out_stall_i);
  assign elapsed = cls_i.now_ms - last_q;
  assign armed   = (mode_q == sslw_pkg::MODE_UNSAFE) || (mode_q == sslw_pkg::MODE_IGNITE);

  always_comb begin
    mode_d      = mode_q;
    time_d      = time_q;
    last_d      = last_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    tmo         = 1'b0;
    taken       = 1'b0;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (pop_o) begin
      if (cls_i.is_tick) begin
        time_d = cls_i.now_ms;
        tmo    = armed && (elapsed >= {16'd0, timeout_i});
        if (tmo) begin
          mode_d = sslw_pkg::MODE_ABORT;
        end else if (mode_q == sslw_pkg::MODE_INIT) begin
          mode_d = sslw_pkg::MODE_SAFE;
        end
      end else if (cls_i.hdr_ok) begin
        // stamp with the last tick time, not the datagram's own time field
        last_d = time_q;
        taken  = cls_i.req_ok && sslw_pkg::move_ok(mode_q, cls_i.req_state);
        if (taken) begin
          mode_d = cls_i.req_state;
        end
      end
      out_valid_d         = 1'b1;
      out_d.machine_state = mode_d;
      out_d.request_taken = taken;
      out_d.timeout_abort = tmo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= sslw_pkg::MODE_INIT;
      time_q      <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      time_q      <= time_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `SSLW_ASSERT_NOW(a_flags_excl, out_valid_q, !(out_q.request_taken && out_q.timeout_abort), "taken and timeout both set")
  `SSLW_ASSERT_NOW(a_tmo_abort, out_valid_q && out_q.timeout_abort, out_q.machine_state == sslw_pkg::MODE_ABORT, "timeout without abort")
  `SSLW_ASSERT_NEXT(a_tick_leaves_init, pop_o && cls_i.is_tick, mode_q != sslw_pkg::MODE_INIT, "still init after tick")

endmodule

`default_nettype wire

@@ hdl/safety_state_machine_link_watchdog_core.sv @@
// Station supervisory state machine with link watchdog.
// Input channel (in_valid_i / in_stall_o, in_item_i): each item is a
// millisecond tick (kind 0) or a received datagram (kind 1). Output channel
// (out_valid_o / out_stall_i, out_item_o): one result per item, in order,
// with the state after the item and the taken/timeout flags.
// Config: cfg_we_i writes cfg_wdata_i to register cfg_idx_i (0 own id,
// 1 broadcast id, 2 request code, 3 min header length, 4 timeout in ms);
// other indexes are ignored. Write only while the block is empty.
// An accepted item is written into the queue, then its result into the
// output register. Throughput: one item per cycle unless the output stalls;
// the back end updates state, time stamps and the timeout compare per item.
// Reset: state init, tick time and last-receive time zero, registers at
// their defaults, queue and output register empty.
// A stalled result holds in the output register; items keep landing in the
// QueueDepth-entry queue and in_stall_o rises once it is full.
`default_nettype none

module safety_state_machine_link_watchdog_core #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  sslw_pkg::in_item_t               in_item_i,
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output sslw_pkg::out_item_t              out_item_o,
  input  wire                              cfg_we_i,
  input  wire [sslw_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire [sslw_pkg::CfgDataW-1:0]     cfg_wdata_i
);

  localparam int unsigned ClsW = $bits(sslw_pkg::cls_item_t);

  sslw_pkg::cfg_t      cfg_q;
  sslw_pkg::cls_item_t cls_in, cls_out;
  logic [ClsW-1:0]     q_rdata;
  logic                push, pop, q_full, q_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.own_id   <= sslw_pkg::OwnIdRst;
      cfg_q.bcast_id <= sslw_pkg::BcastIdRst;
      cfg_q.req_code <= sslw_pkg::ReqCodeRst;
      cfg_q.min_hdr  <= sslw_pkg::MinHdrRst;
      cfg_q.timeout  <= sslw_pkg::TimeoutRst;
    end else if (cfg_we_i) begin
      unique case (sslw_pkg::cfg_idx_e'(cfg_idx_i))
        sslw_pkg::CFG_OWN_ID:   cfg_q.own_id   <= cfg_wdata_i[7:0];
        sslw_pkg::CFG_BCAST_ID: cfg_q.bcast_id <= cfg_wdata_i[7:0];
        sslw_pkg::CFG_REQ_CODE: cfg_q.req_code <= cfg_wdata_i[7:0];
        sslw_pkg::CFG_MIN_HDR:  cfg_q.min_hdr  <= cfg_wdata_i[7:0];
        sslw_pkg::CFG_TIMEOUT:  cfg_q.timeout  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  sslw_front u_front (
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .cfg_i      (cfg_q),
    .q_full_i   (q_full),
    .in_stall_o (in_stall_o),
    .push_o     (push),
    .cls_o      (cls_in)
  );

  sslw_queue #(
    .Width (ClsW),
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cls_in),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .data_o  (q_rdata)
  );

  assign cls_out = sslw_pkg::cls_item_t'(q_rdata);

  sslw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .cls_i       (cls_out),
    .timeout_i   (cfg_q.timeout),
    .pop_o       (pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire
